/* sv/lph_pkg.sv */
// shared constants, codes and controller/datapath interface types for the hash table
package lph_pkg;

    localparam int DEF_TABLE_SLOTS = 1024;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_DATA_BITS   = 32;

    localparam int FIELD_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 10;
    localparam int HASH_STEPS = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW       = 3'd0,
        ST_OVERWRITE = 3'd1,
        ST_FULL      = 3'd2,
        ST_HIT       = 3'd3,
        ST_MISS      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic load_req;
        logic load_home;
        logic probe_adv;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hash_done;
        logic slot_valid;
        logic key_match;
        logic probe_last;
        logic out_free;
    } sts_t;

endpackage

/* sv/linear_probe_hash_table.sv */
// top level of the linear-probing key/value hash table
// Open-addressing key/value table with linear probing. After reset the block
// runs a clearing pass over the slot valid store, one slot per cycle, so it
// takes no request until all TABLE_SLOTS slots (1024 by default) are cleared;
// the miss value register can be written during that time. Each request is
// an insert or a lookup; the home slot is hash_value modulo TABLE_SLOTS. One
// request is worked at a time: the transfer, then forming the home slot (a
// mask when TABLE_SLOTS is a power of two, a reciprocal-multiply remainder
// unit otherwise), then the first slot read, then the probe walk, in which
// each probe waits on the registered read of the slot stores.
// Results sit in an output register, so a request is taken while the
// previous result still waits; the commit of the next result waits until
// that register is free.
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lph_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = lph_pkg::DEF_KEY_BITS,
    parameter int DATA_BITS   = lph_pkg::DEF_DATA_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // miss value register write
    input  logic                            cfg_wr_en,
    input  logic [lph_pkg::FIELD_W-1:0]     cfg_wr_data,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            operation,
    input  logic [lph_pkg::FIELD_W-1:0]     key,
    input  logic [lph_pkg::FIELD_W-1:0]     hash_value,
    input  logic [lph_pkg::FIELD_W-1:0]     data_value,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lph_pkg::STATUS_W-1:0]    status,
    output logic [lph_pkg::FIELD_W-1:0]     read_value,
    output logic [lph_pkg::SLOT_OUT_W-1:0]  slot_index
);
    import lph_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // controller: sequencing only, no payload
    lph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: slot stores, probe address, result register
    lph_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS),
        .DATA_BITS   (DATA_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .operation   (operation),
        .key         (key),
        .hash_value  (hash_value),
        .data_value  (data_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_value  (read_value),
        .slot_index  (slot_index)
    );

    // a request transfer puts the block to work, so no second transfer follows at once
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while previous one still in flight");

    // a result is never committed over one that has not been taken
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || out_ready))
        else $error("result register overwritten before transfer");

    // the walk only steps past a valid slot with another key, and never past the bound
    a_probe_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_adv |-> (sts.slot_valid && !sts.key_match && !sts.probe_last))
        else $error("probe advanced past a stopping slot");

    // requests wait until the clearing pass is over
    a_no_transfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> (!in_ready && !cmd.commit))
        else $error("request activity during clearing pass");

endmodule

/* sv/lph_ram.sv */
// generic single write port ram with registered read
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/lph_ctrl.sv */
// sequencing state machine: clearing pass, hash reduction, probe walk, commit
module lph_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  lph_pkg::sts_t sts,
    output lph_pkg::cmd_t cmd
);
    import lph_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   decided;

    // probe ends at an empty slot, a matching key, or at the last slot of a full lap
    assign decided = !sts.slot_valid || sts.key_match || sts.probe_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (sts.hash_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (decided && sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            S_HASH:
            begin
                cmd.load_home = sts.hash_done;
            end
            S_READ:
            begin
            end
            S_CHECK:
            begin
                cmd.probe_adv = !decided;
                cmd.commit    = decided && sts.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* sv/lph_datapath.sv */
// request registers, home slot reduction, slot stores, probe address and result register
module lph_datapath #(
    parameter int TABLE_SLOTS = lph_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = lph_pkg::DEF_KEY_BITS,
    parameter int DATA_BITS   = lph_pkg::DEF_DATA_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lph_pkg::cmd_t                   cmd,
    output lph_pkg::sts_t                   sts,
    input  logic                            cfg_wr_en,
    input  logic [lph_pkg::FIELD_W-1:0]     cfg_wr_data,
    input  logic                            operation,
    input  logic [lph_pkg::FIELD_W-1:0]     key,
    input  logic [lph_pkg::FIELD_W-1:0]     hash_value,
    input  logic [lph_pkg::FIELD_W-1:0]     data_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lph_pkg::STATUS_W-1:0]    status,
    output logic [lph_pkg::FIELD_W-1:0]     read_value,
    output logic [lph_pkg::SLOT_OUT_W-1:0]  slot_index
);
    import lph_pkg::*;

    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
    localparam int ENTRY_W   = KEY_BITS + DATA_BITS;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_SLOTS - 1);
    localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

    logic [FIELD_W-1:0]   miss_value_reg;
    logic                 req_op_reg;
    logic [KEY_BITS-1:0]  req_key_reg;
    logic [DATA_BITS-1:0] req_data_reg;
    logic [SLOT_BITS-1:0] home_slot;
    logic                 hash_done;

    logic [SLOT_BITS-1:0] clr_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [SLOT_BITS-1:0] slot_inc;
    logic [SLOT_BITS-1:0] probe_cnt_reg;
    logic [SLOT_BITS-1:0] rd_addr;

    logic                 valid_wr_en;
    logic [SLOT_BITS-1:0] valid_wr_addr;
    logic                 valid_wr_data;
    logic                 rd_valid;
    logic                 entry_wr_en;
    logic [ENTRY_W-1:0]   entry_rd;
    logic [KEY_BITS-1:0]  rd_key;
    logic [DATA_BITS-1:0] rd_data;

    logic                 is_insert;
    logic                 key_eq;
    status_t              res_status;
    logic [FIELD_W-1:0]   res_value;
    logic [SLOT_BITS-1:0] res_slot;

    logic                 out_valid_reg;
    status_t              status_reg;
    logic [FIELD_W-1:0]   read_value_reg;
    logic [SLOT_OUT_W-1:0] slot_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_value_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            miss_value_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_op_reg   <= operation;
            req_key_reg  <= KEY_BITS'(key);
            req_data_reg <= DATA_BITS'(data_value);
        end
    end

    // home slot: mask for power-of-two sizes, reciprocal multiply and one correction otherwise
    generate
        if (IS_POW2)
        begin : g_mask
            logic [SLOT_BITS-1:0] hsh_reg;

            always_ff @(posedge clk)
            begin
                if (cmd.load_req)
                begin
                    hsh_reg <= hash_value[SLOT_BITS-1:0];
                end
            end

            assign home_slot = hsh_reg;
            assign hash_done = 1'b1;
        end
        else
        begin : g_mod
            localparam int RB       = SLOT_BITS + 1;
            localparam int CNT_BITS = $clog2(HASH_STEPS);
            localparam logic [FIELD_W-1:0] RECIP =
                FIELD_W'((64'd1 << FIELD_W) / TABLE_SLOTS);
            localparam logic [RB-1:0] SLOTS_R = RB'(TABLE_SLOTS);

            logic [FIELD_W-1:0]   hsh_reg;
            logic [2*FIELD_W-1:0] recip_prod;
            logic [RB-1:0]        quot_reg;
            logic [RB-1:0]        quot_slots;
            logic [RB-1:0]        qn_reg;
            logic [RB-1:0]        rem_reg;
            logic [RB-1:0]        rem_fix;
            logic [CNT_BITS-1:0]  cnt_reg;
            logic                 busy_reg;

            // quotient estimate is low by at most one, so the remainder
            // estimate stays below twice the table size; only low bits matter
            assign recip_prod = (2*FIELD_W)'(hsh_reg) * (2*FIELD_W)'(RECIP);
            assign quot_slots = quot_reg * SLOTS_R;
            assign rem_fix    = rem_reg - SLOTS_R;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else if (cmd.load_req)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
                else if (busy_reg)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_BITS'(HASH_STEPS - 1))
                    begin
                        busy_reg <= 1'b0;
                    end
                end
            end

            // three-stage pipe: quotient, quotient times size, remainder
            always_ff @(posedge clk)
            begin
                if (cmd.load_req)
                begin
                    hsh_reg <= hash_value;
                end
                else if (busy_reg)
                begin
                    quot_reg <= recip_prod[FIELD_W +: RB];
                    qn_reg   <= quot_slots;
                    rem_reg  <= hsh_reg[RB-1:0] - qn_reg;
                end
            end

            assign home_slot = (rem_reg >= SLOTS_R) ? rem_fix[SLOT_BITS-1:0]
                                                    : rem_reg[SLOT_BITS-1:0];
            assign hash_done = !busy_reg;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    assign slot_inc = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.load_home)
        begin
            slot_reg      <= home_slot;
            probe_cnt_reg <= '0;
        end
        else if (cmd.probe_adv)
        begin
            slot_reg      <= slot_inc;
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
    end

    // next probe address goes out in the same cycle the current one is checked
    assign rd_addr = cmd.probe_adv ? slot_inc : slot_reg;

    assign is_insert = (req_op_reg == OP_INSERT);
    assign key_eq    = rd_valid && (rd_key == req_key_reg);

    assign valid_wr_en   = cmd.clear_wr || (cmd.commit && is_insert && !rd_valid);
    assign valid_wr_addr = cmd.clear_wr ? clr_reg : slot_reg;
    assign valid_wr_data = !cmd.clear_wr;
    assign entry_wr_en   = cmd.commit && is_insert && (!rd_valid || key_eq);

    lph_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_SLOTS)
    ) u_valid_ram (
        .clk     (clk),
        .wr_en   (valid_wr_en),
        .wr_addr (valid_wr_addr),
        .wr_data (valid_wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_valid)
    );

    lph_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (entry_wr_en),
        .wr_addr (slot_reg),
        .wr_data ({req_key_reg, req_data_reg}),
        .rd_addr (rd_addr),
        .rd_data (entry_rd)
    );

    assign rd_key  = entry_rd[ENTRY_W-1:DATA_BITS];
    assign rd_data = entry_rd[DATA_BITS-1:0];

    always_comb
    begin
        res_status = ST_FULL;
        res_value  = '0;
        res_slot   = '0;
        if (is_insert)
        begin
            if (key_eq)
            begin
                res_status = ST_OVERWRITE;
                res_slot   = slot_reg;
            end
            else if (!rd_valid)
            begin
                res_status = ST_NEW;
                res_slot   = slot_reg;
            end
        end
        else
        begin
            if (key_eq)
            begin
                res_status = ST_HIT;
                res_value  = FIELD_W'(rd_data);
                res_slot   = slot_reg;
            end
            else
            begin
                res_status = ST_MISS;
                res_value  = miss_value_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg     <= res_status;
            read_value_reg <= res_value;
            slot_index_reg <= SLOT_OUT_W'(res_slot);
        end
    end

    assign sts.clr_last   = (clr_reg == LAST_SLOT);
    assign sts.hash_done  = hash_done;
    assign sts.slot_valid = rd_valid;
    assign sts.key_match  = key_eq;
    assign sts.probe_last = (probe_cnt_reg == LAST_SLOT);
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign slot_index = slot_index_reg;

endmodule

/* tb/hash_table_checker.sv */
// checker for the hash table: mirrors the slot stores, predicts and compares every result
module hash_table_checker #(
    parameter int TABLE_SLOTS = lph_pkg::DEF_TABLE_SLOTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lph_pkg::FIELD_W-1:0]     cfg_wr_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            operation,
    input  logic [lph_pkg::FIELD_W-1:0]     key,
    input  logic [lph_pkg::FIELD_W-1:0]     hash_value,
    input  logic [lph_pkg::FIELD_W-1:0]     data_value,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [lph_pkg::STATUS_W-1:0]    status,
    input  logic [lph_pkg::FIELD_W-1:0]     read_value,
    input  logic [lph_pkg::SLOT_OUT_W-1:0]  slot_index,
    output int                              mismatch_count,
    output int                              pending_results,
    output int                              occupied_slots
);
    timeunit 1ns;
    timeprecision 1ps;

    import lph_pkg::*;

    typedef struct packed {
        status_t                 st;
        logic [FIELD_W-1:0]      value;
        logic [SLOT_OUT_W-1:0]   slot;
    } table_reply_t;

    bit                 slot_used   [TABLE_SLOTS];
    logic [FIELD_W-1:0] stored_key  [TABLE_SLOTS];
    logic [FIELD_W-1:0] stored_data [TABLE_SLOTS];
    logic [FIELD_W-1:0] miss_word;
    table_reply_t       replies_due [$];
    int                 errors = 0;
    int                 used_count = 0;

    // walk from the home slot until the key or an empty slot, at most one lap
    function automatic table_reply_t predict_access(input logic op,
                                                    input logic [FIELD_W-1:0] k,
                                                    input logic [FIELD_W-1:0] h,
                                                    input logic [FIELD_W-1:0] d);
        int unsigned  pos;
        bit           hit;
        bit           vacant;
        table_reply_t r;
        pos    = h % TABLE_SLOTS;
        hit    = 1'b0;
        vacant = 1'b0;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            if (!slot_used[pos]) begin
                vacant = 1'b1;
                break;
            end
            if (stored_key[pos] == k) begin
                hit = 1'b1;
                break;
            end
            pos = (pos + 1) % TABLE_SLOTS;
        end
        r.value = '0;
        r.slot  = '0;
        if (op == OP_INSERT) begin
            if (hit) begin
                stored_data[pos] = d;
                r.st   = ST_OVERWRITE;
                r.slot = SLOT_OUT_W'(pos);
            end else if (vacant) begin
                slot_used[pos]   = 1'b1;
                stored_key[pos]  = k;
                stored_data[pos] = d;
                used_count++;
                r.st   = ST_NEW;
                r.slot = SLOT_OUT_W'(pos);
            end else begin
                r.st = ST_FULL;
            end
        end else begin
            if (hit) begin
                r.st    = ST_HIT;
                r.value = stored_data[pos];
                r.slot  = SLOT_OUT_W'(pos);
            end else begin
                r.st    = ST_MISS;
                r.value = miss_word;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        table_reply_t seen;
        table_reply_t want;
        if (!rst_n) begin
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            miss_word  = '0;
            used_count = 0;
            replies_due.delete();
        end else begin
            if (cfg_wr_en)
                miss_word = cfg_wr_data;
            // compare before queuing a same-cycle request, its result comes later
            if (out_valid && out_ready) begin
                seen = '{status_t'(status), read_value, slot_index};
                if (replies_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("tb: result with nothing pending: status %0d value %h slot %0d",
                                 status, read_value, slot_index);
                end else begin
                    want = replies_due.pop_front();
                    if (seen !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"tb: mismatch: status exp %0d got %0d, ",
                                      "value exp %h got %h, slot exp %0d got %0d"},
                                     want.st, status, want.value, read_value,
                                     want.slot, slot_index);
                    end
                end
            end
            if (in_valid && in_ready)
                replies_due.push_back(predict_access(operation, key, hash_value, data_value));
        end
        mismatch_count  <= errors;
        pending_results <= replies_due.size();
        occupied_slots  <= used_count;
    end

endmodule

/* tb/tb.sv */
// testbench top for the linear-probing hash table: stimulus, receiver stalls and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lph_pkg::*;

    localparam int TABLE_SLOTS  = DEF_TABLE_SLOTS;
    localparam int KEY_POOL     = 320;
    localparam int MIXED_ITEMS  = 800;
    localparam int FULL_ITEMS   = 100;
    localparam int FILL_MAX     = TABLE_SLOTS + 64;
    // watchdog bound, set from the slowest correct run: every request walking a
    // full lap, plus sender gaps and receiver stalls
    localparam int CYCLE_LIMIT  = 8_000_000;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [FIELD_W-1:0]     cfg_wr_data = '0;
    logic                   in_valid    = 1'b0;
    logic                   operation   = OP_INSERT;
    logic [FIELD_W-1:0]     key         = '0;
    logic [FIELD_W-1:0]     hash_value  = '0;
    logic [FIELD_W-1:0]     data_value  = '0;
    logic                   out_ready   = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    logic [STATUS_W-1:0]    status;
    logic [FIELD_W-1:0]     read_value;
    logic [SLOT_OUT_W-1:0]  slot_index;

    int mismatch_count;
    int pending_results;
    int occupied_slots;

    // sender burst state and run statistics
    int burst_left  = 0;
    int n_inserts   = 0;
    int n_lookups   = 0;
    int n_cfg       = 0;
    int cycle_count = 0;

    // key pool for the mixed phase, each key with a fixed client hash
    logic [FIELD_W-1:0] pool_key  [KEY_POOL];
    logic [FIELD_W-1:0] pool_hash [KEY_POOL];
    // keys placed while filling the table, reused once it is full
    logic [FIELD_W-1:0] fill_key  [FILL_MAX];
    logic [FIELD_W-1:0] fill_hash [FILL_MAX];
    int                 n_fill = 0;

    // receiver stall pattern state
    int       ready_mode = 0;
    int       mode_left  = 0;
    logic [3:0] stall_tick = '0;

    initial begin
        forever #2 clk = ~clk;
    end

    linear_probe_hash_table #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .key         (key),
        .hash_value  (hash_value),
        .data_value  (data_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_value  (read_value),
        .slot_index  (slot_index)
    );

    hash_table_checker #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .key             (key),
        .hash_value      (hash_value),
        .data_value      (data_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .read_value      (read_value),
        .slot_index      (slot_index),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .occupied_slots  (occupied_slots)
    );

    // receiver: switches between always ready, random stalls and long
    // periodic stalls (ready only while the 4-bit stall_tick is below 4)
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            stall_tick <= stall_tick + 1'b1;
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(50, 300);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= (stall_tick < 4'd4);
            endcase
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results);
            $display("tb: FAIL");
            $finish;
        end
    end

    // mostly random data, now and then all zeros or all ones
    function automatic logic [FIELD_W-1:0] pick_data();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // one request transfer; between bursts the sender drops valid for a
    // random gap, and some bursts are long stretches with no idling at all
    task automatic send_request(input logic op, input logic [FIELD_W-1:0] k,
                                input logic [FIELD_W-1:0] h, input logic [FIELD_W-1:0] d);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(100, 300);
            else
                burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        key        <= k;
        hash_value <= h;
        data_value <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        if (op == OP_INSERT)
            n_inserts++;
        else
            n_lookups++;
    endtask

    // wait until every result has come back; the checker's counts are
    // registered, so look in the cycle after the last transfer
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // miss value register write; callers must use it only while the block is idle, unchecked
    task automatic write_miss_value(input logic [FIELD_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        n_cfg++;
    endtask

    initial begin
        int                 pick;
        int                 idx;
        logic [FIELD_W-1:0] k;
        logic [FIELD_W-1:0] h;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the block is still clearing its slots, the register write is allowed
        write_miss_value('1);

        // directed: empty table, extremes, wrap at the last slot, overwrite
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'hDEAD_BEEF); // miss, all ones
        send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000); // new at slot 0
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // new at last slot
        // home is the last slot, taken: walk wraps past slot 0 to slot 1
        send_request(OP_INSERT, 32'h1234_5678, 32'h0000_03FF, 32'h5555_5555);
        // same home through different upper hash bits, hit after the wrap
        send_request(OP_LOOKUP, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FC00, 32'hA5A5_A5A5); // overwrite slot 0
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF); // data ignored
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h8000_03FF, 32'h0000_0000); // hit last slot
        // absent key walks the wrapped cluster and stops at empty slot 2
        send_request(OP_LOOKUP, 32'hAAAA_AAAA, 32'h0000_03FF, 32'h0000_0000);
        send_request(OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000);
        send_request(OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        // present key but wrong home: stops at the empty neighbour, miss
        send_request(OP_LOOKUP, 32'h5555_5555, 32'h5555_5555, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000);
        send_request(OP_INSERT, 32'h1234_5678, 32'h0000_03FF, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, 32'h1234_5678, 32'h0000_03FF, 32'h0000_0000);
        drain();
        write_miss_value($urandom);

        // key pool: many homes squeezed into a narrow window for long probe
        // chains, some near the top of the table so the walks wrap
        for (int i = 0; i < KEY_POOL; i++) begin
            pool_key[i]  = $urandom;
            pool_hash[i] = $urandom;
            pick = $urandom_range(0, 9);
            if (pick < 4)
                pool_hash[i][9:0] = 10'($urandom_range(200, 263));
            else if (pick < 5)
                pool_hash[i][9:0] = 10'($urandom_range(1016, 1023));
        end

        // mixed phase: consistent key/hash pairs, a few with a wrong hash,
        // and some pure noise
        for (int i = 0; i < MIXED_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, KEY_POOL - 1);
            if (pick < 6)
                send_request(1'($urandom), $urandom, $urandom, $urandom);
            else if (pick < 10)
                send_request(1'($urandom), pool_key[idx], $urandom, pick_data());
            else if (pick < 55)
                send_request(OP_INSERT, pool_key[idx], pool_hash[idx], pick_data());
            else
                send_request(OP_LOOKUP, pool_key[idx], pool_hash[idx], pick_data());
        end
        drain();
        write_miss_value('0);

        // fill the table to capacity; homes mostly step through the slots,
        // some random ones walk far as the table closes up
        while (occupied_slots < TABLE_SLOTS) begin
            k = $urandom;
            h = $urandom;
            if ($urandom_range(0, 3) != 0)
                h[9:0] = 10'(n_fill);
            fill_key[n_fill]  = k;
            fill_hash[n_fill] = h;
            if (n_fill < FILL_MAX - 1)
                n_fill++;
            send_request(OP_INSERT, k, h, pick_data());
        end
        drain();

        // full table: new key is refused, absent key misses after a full lap,
        // present keys still hit and overwrite
        send_request(OP_INSERT, $urandom, $urandom, pick_data());
        send_request(OP_LOOKUP, $urandom, $urandom, pick_data());
        send_request(OP_LOOKUP, fill_key[0], fill_hash[0], '0);
        send_request(OP_INSERT, fill_key[n_fill - 1], fill_hash[n_fill - 1], '1);
        drain();
        write_miss_value($urandom);

        for (int i = 0; i < FULL_ITEMS; i++) begin
            if (i == FULL_ITEMS / 2) begin
                drain();
                write_miss_value('1);
            end
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, n_fill - 1);
            if (pick < 40)
                send_request(OP_LOOKUP, fill_key[idx], fill_hash[idx], pick_data());
            else if (pick < 55)
                send_request(OP_LOOKUP, $urandom, $urandom, pick_data());
            else if (pick < 75)
                send_request(OP_INSERT, fill_key[idx], fill_hash[idx], pick_data());
            else if (pick < 90)
                send_request(OP_INSERT, $urandom, $urandom, pick_data());
            else
                send_request(1'($urandom), $urandom, $urandom, $urandom);
        end
        drain();

        // quiet tail to catch any stray result
        repeat (32) @(posedge clk);

        $display("tb: %0d requests (%0d inserts, %0d lookups), table filled to %0d of %0d slots",
                 n_inserts + n_lookups, n_inserts, n_lookups, occupied_slots, TABLE_SLOTS);
        $display("tb: miss value written %0d times, %0d mismatches, %0d cycles",
                 n_cfg, mismatch_count, cycle_count);
        if (mismatch_count == 0 && pending_results == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/lph_pkg.sv
sv/lph_ram.sv
sv/lph_ctrl.sv
sv/lph_datapath.sv
sv/linear_probe_hash_table.sv
tb/hash_table_checker.sv
tb/tb.sv
